FILE: design/rss_pkg.sv
package rss_pkg;

    // Field widths of the words on the ports.
    localparam int SAMPLE_W     = 16;
    localparam int COUNT_OUT_W  = 16;
    localparam int MEAN_W       = 24;
    localparam int DEV_W        = 24;

    // Fixed-point scaling of the mean and of the variance before the root.
    localparam int MEAN_SHIFT   = 8;
    localparam int DEV_SHIFT    = 16;

    // The root unit works on a 48-bit radicand and yields 24 result bits.
    localparam int ROOT_W       = 48;
    localparam int ROOT_STEPS   = 24;
    localparam logic [ROOT_W-1:0] ROOT_TOP = ROOT_W'(1) << (ROOT_W - 2);

    // Divider numerator width: (n*sumsq - sum^2) << 16, so the root has 8 fraction bits.
    function automatic int num_width(input int sample_bits, input int count_bits);
        num_width = 2 * sample_bits + 2 * count_bits - 2 + DEV_SHIFT;
    endfunction

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_set;
        logic                       last_of_set;
    } t_in_word;

    typedef struct packed {
        logic        [COUNT_OUT_W-1:0] sample_count;
        logic signed [MEAN_W-1:0]      mean_q8;
        logic signed [SAMPLE_W-1:0]    minimum_value;
        logic signed [SAMPLE_W-1:0]    maximum_value;
        logic        [DEV_W-1:0]       std_dev_q8;
        logic                          std_dev_valid;
        logic                          count_overflow;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MEAN_DIV,
        ST_MEAN_END,
        ST_DEV_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic calc_load;
        logic mul_step;
        logic div_step;
        logic mean_save;
        logic dev_load;
        logic root_load;
        logic root_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_set;
    } t_sts;

endpackage

FILE: design/rss_datapath.sv
module rss_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rss_pkg::t_in_word  i_in_word,
    input  rss_pkg::t_cmd      i_cmd,
    output rss_pkg::t_sts      o_sts,
    output rss_pkg::t_out_word o_out_word
);
    import rss_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int CB      = COUNT_BITS;
    localparam int IN_BITS = (SB < SAMPLE_W) ? SB : SAMPLE_W;
    localparam int SQR_W   = 2 * SB - 1;
    localparam int SUM_W   = SB + CB;
    localparam int SQ_W    = 2 * SB - 2 + CB;
    localparam int PROD_W  = 2 * SUM_W;
    localparam int DIFF_W  = 2 * SB + 2 * CB - 2;
    localparam int NUM_W   = num_width(SB, CB);
    localparam int DVS_W   = 2 * CB;
    localparam int QX_W    = ((NUM_W > ROOT_W) ? NUM_W : ROOT_W) + 1;
    localparam int SMP_EW  = (SB > SAMPLE_W) ? SB : SAMPLE_W;
    localparam int CNT_EW  = (CB > COUNT_OUT_W) ? CB : COUNT_OUT_W;

    localparam logic signed [SB-1:0] SAMPLE_POS = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_NEG = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [NUM_W-1:0] MEAN_POS_MAG = NUM_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] MEAN_NEG_MAG = NUM_W'(64'd1 << (MEAN_W - 1));

    // Running statistics.
    logic        [CB-1:0]    r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic        [SQ_W-1:0]  r_sumsq, n_sumsq;
    logic signed [SB-1:0]    r_min, n_min;
    logic signed [SB-1:0]    r_max, n_max;
    logic                    r_ovf, n_ovf;

    // Shift-and-add multipliers for n*sumsq and sum^2, and the divisor n*(n-1).
    logic [PROD_W-1:0] r_acc_a, r_acc_b, r_cand_a, r_cand_b;
    logic [CB-1:0]     r_plier_a;
    logic [SUM_W-1:0]  r_plier_b;
    logic [DVS_W-1:0]  r_dvs;

    // Restoring divider, one quotient bit per cycle.
    logic [NUM_W-1:0]  r_num, r_quo;
    logic [DVS_W-1:0]  r_rem, r_dvsr;

    // Bitwise square root.
    logic [ROOT_W-1:0] r_rx, r_rres, r_rbit;
    logic              r_rsat;

    logic signed [MEAN_W-1:0] r_mean;
    t_out_word                r_out;

    logic signed [IN_BITS-1:0] smp_raw;
    logic signed [SB-1:0]      smp;
    logic signed [2*SB-1:0]    smp_prod;
    logic [SQR_W-1:0]          smp_sq;
    logic [CB-1:0]             b_count;
    logic signed [SUM_W-1:0]   b_sum;
    logic [SQ_W-1:0]           b_sumsq;
    logic signed [SB-1:0]      b_min, b_max;
    logic                      b_ovf;

    logic [SUM_W-1:0]   sum_mag;
    logic [PROD_W-1:0]  dev_diff;
    logic [DVS_W:0]     div_try, div_sub;
    logic               div_ge;
    logic [QX_W-1:0]    quo_ext;
    logic [ROOT_W:0]    root_sum;
    logic               root_ge;
    logic               short_set;
    logic [MEAN_W-1:0]  mean_val;
    logic [CNT_EW-1:0]  cnt_ext;
    logic signed [SMP_EW-1:0] min_ext, max_ext;
    logic signed [SMP_EW-1:0] out_pos_ext, out_neg_ext;

    // Input sample: low bits taken and sign-extended, and its square.
    assign smp_raw  = i_in_word.sample[IN_BITS-1:0];
    assign smp      = SB'(smp_raw);
    assign smp_prod = smp * smp;
    assign smp_sq   = smp_prod[SQR_W-1:0];

    // Next statistics: optional clear, then add the sample unless the count is full.
    always_comb begin
        b_count = r_count;
        b_sum   = r_sum;
        b_sumsq = r_sumsq;
        b_min   = r_min;
        b_max   = r_max;
        b_ovf   = r_ovf;
        if (i_in_word.first_of_set) begin
            b_count = '0;
            b_sum   = '0;
            b_sumsq = '0;
            b_min   = SAMPLE_POS;
            b_max   = SAMPLE_NEG;
            b_ovf   = 1'b0;
        end
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_min   = r_min;
        n_max   = r_max;
        n_ovf   = r_ovf;
        if (i_cmd.acc_en) begin
            n_count = b_count;
            n_sum   = b_sum;
            n_sumsq = b_sumsq;
            n_min   = b_min;
            n_max   = b_max;
            n_ovf   = b_ovf;
            if (b_count == '1) begin
                n_ovf = 1'b1;
            end else begin
                n_count = b_count + 1'b1;
                n_sum   = b_sum + SUM_W'(smp);
                n_sumsq = b_sumsq + SQ_W'(smp_sq);
                n_min   = (smp < b_min) ? smp : b_min;
                n_max   = (smp > b_max) ? smp : b_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_min   <= SAMPLE_POS;
            r_max   <= SAMPLE_NEG;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_min   <= n_min;
            r_max   <= n_max;
            r_ovf   <= n_ovf;
        end
    end

    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign short_set = (r_count < CB'(2));
    assign o_sts.short_set = short_set;

    // The variance numerator never goes negative in exact arithmetic; clamp at zero.
    assign dev_diff = (r_acc_a >= r_acc_b) ? (r_acc_a - r_acc_b) : '0;

    // One divider step: shift in the next numerator bit and try a subtract.
    assign div_try = {r_rem, r_num[NUM_W-1]};
    assign div_sub = div_try - {1'b0, r_dvsr};
    assign div_ge  = (div_try >= {1'b0, r_dvsr});

    assign quo_ext = QX_W'(r_quo);

    // One root step.
    assign root_sum = {1'b0, r_rres} + {1'b0, r_rbit};
    assign root_ge  = ({1'b0, r_rx} >= root_sum);

    // Mean: sign applied to the magnitude quotient, then clamped to the field.
    always_comb begin
        if (r_count == '0) begin
            mean_val = '0;
        end else if (!r_sum[SUM_W-1]) begin
            mean_val = (r_quo > MEAN_POS_MAG) ? {1'b0, {(MEAN_W - 1){1'b1}}}
                                              : r_quo[MEAN_W-1:0];
        end else begin
            mean_val = (r_quo > MEAN_NEG_MAG) ? {1'b1, {(MEAN_W - 1){1'b0}}}
                                              : MEAN_W'(-r_quo[MEAN_W-1:0]);
        end
    end

    // Output clamps for wider counts and samples.
    assign cnt_ext     = CNT_EW'(r_count);
    assign min_ext     = SMP_EW'(r_min);
    assign max_ext     = SMP_EW'(r_max);
    assign out_pos_ext = SMP_EW'($signed({1'b0, {(SAMPLE_W - 1){1'b1}}}));
    assign out_neg_ext = SMP_EW'($signed({1'b1, {(SAMPLE_W - 1){1'b0}}}));

    // Report arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_load) begin
            r_acc_a   <= '0;
            r_acc_b   <= '0;
            r_cand_a  <= PROD_W'(r_sumsq);
            r_cand_b  <= PROD_W'(sum_mag);
            r_plier_a <= r_count;
            r_plier_b <= sum_mag;
            r_dvs     <= DVS_W'(r_count) * DVS_W'(r_count - 1'b1);
        end else if (i_cmd.mul_step) begin
            if (r_plier_a[0]) begin
                r_acc_a <= r_acc_a + r_cand_a;
            end
            if (r_plier_b[0]) begin
                r_acc_b <= r_acc_b + r_cand_b;
            end
            r_cand_a  <= r_cand_a << 1;
            r_cand_b  <= r_cand_b << 1;
            r_plier_a <= r_plier_a >> 1;
            r_plier_b <= r_plier_b >> 1;
        end

        if (i_cmd.calc_load) begin
            r_num  <= NUM_W'({sum_mag, {MEAN_SHIFT{1'b0}}});
            r_rem  <= '0;
            r_dvsr <= DVS_W'(r_count);
        end else if (i_cmd.dev_load) begin
            r_num  <= {dev_diff[DIFF_W-1:0], {DEV_SHIFT{1'b0}}};
            r_rem  <= '0;
            r_dvsr <= r_dvs;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_rem <= div_ge ? div_sub[DVS_W-1:0] : div_try[DVS_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], div_ge};
        end

        if (i_cmd.mean_save) begin
            r_mean <= mean_val;
        end

        if (i_cmd.root_load) begin
            r_rx   <= quo_ext[ROOT_W-1:0];
            r_rsat <= |quo_ext[QX_W-1:ROOT_W];
            r_rres <= '0;
            r_rbit <= ROOT_TOP;
        end else if (i_cmd.root_step) begin
            if (root_ge) begin
                r_rx   <= r_rx - root_sum[ROOT_W-1:0];
                r_rres <= (r_rres >> 1) + r_rbit;
            end else begin
                r_rres <= r_rres >> 1;
            end
            r_rbit <= r_rbit >> 2;
        end

        // Result word register.
        if (i_cmd.out_load) begin
            r_out.sample_count   <= (cnt_ext > CNT_EW'({COUNT_OUT_W{1'b1}}))
                                    ? {COUNT_OUT_W{1'b1}} : cnt_ext[COUNT_OUT_W-1:0];
            r_out.mean_q8        <= r_mean;
            r_out.minimum_value  <= (min_ext > out_pos_ext) ? out_pos_ext[SAMPLE_W-1:0] :
                                    (min_ext < out_neg_ext) ? out_neg_ext[SAMPLE_W-1:0] :
                                    min_ext[SAMPLE_W-1:0];
            r_out.maximum_value  <= (max_ext > out_pos_ext) ? out_pos_ext[SAMPLE_W-1:0] :
                                    (max_ext < out_neg_ext) ? out_neg_ext[SAMPLE_W-1:0] :
                                    max_ext[SAMPLE_W-1:0];
            r_out.std_dev_q8     <= short_set ? '0 : (r_rsat ? '1 : r_rres[DEV_W-1:0]);
            r_out.std_dev_valid  <= !short_set;
            r_out.count_overflow <= r_ovf;
        end
    end

    assign o_out_word = r_out;

endmodule

FILE: design/rss_ctrl.sv
module rss_ctrl #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rss_pkg::t_sts i_sts,
    output rss_pkg::t_cmd o_cmd
);
    import rss_pkg::*;

    localparam int NUM_W  = num_width(SAMPLE_BITS, COUNT_BITS);
    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(NUM_W - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencer: accumulate, then on a report run divide, divide, root, and hand off.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc_en = 1'b1;
                    if (i_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.calc_load = 1'b1;
                n_step          = '0;
                n_state         = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = ST_MEAN_END;
                end
            end
            ST_MEAN_END: begin
                o_cmd.mean_save = 1'b1;
                n_step          = '0;
                if (i_sts.short_set) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.dev_load = 1'b1;
                    n_state        = ST_DEV_DIV;
                end
            end
            ST_DEV_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = ST_ROOT_LOAD;
                end
            end
            ST_ROOT_LOAD: begin
                o_cmd.root_load = 1'b1;
                n_step          = '0;
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == ROOT_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/running_sample_statistics_top.sv
// Running sample statistics. Each input word carries one signed sample; samples are
// taken one per cycle while not stalled and update the count, sum, sum of squares,
// minimum and maximum. A word with first_of_set clears the set before its sample is
// added, and a word with last_of_set produces one result word: count, mean and sample
// standard deviation (n-1 divisor, both with 8 fraction bits), minimum, maximum and
// flags. After a last_of_set word the input stalls while the report is computed by a
// one-bit-per-cycle restoring divider, used once for the mean and once for the
// variance, on a numerator of 2*SAMPLE_BITS + 2*COUNT_BITS + 14 bits, and a
// two-bits-per-cycle square root, and while the previous result word waits to be
// taken. A set of fewer than two samples skips the variance divide and the root.
// Samples arriving once the count is full are dropped and reported through
// count_overflow.
module running_sample_statistics_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rss_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rss_pkg::t_out_word o_out_word
);
    import rss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    rss_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in_word.last_of_set),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Accumulators and report arithmetic.
    rss_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

endmodule
